// ----- rtl/pbtc_pkg.sv -----
// Shared types, codes and constants of the package block-table checker.
`timescale 1ns / 1ps

package pbtc_pkg;

	localparam logic [31:0] MAGIC_WORD       = 32'h9E2A_83C1;
	localparam logic [31:0] PASSTHROUGH_WORD = 32'h002E_0340;
	localparam int unsigned MAX_BLOCKS       = 1048576;
	localparam int unsigned HEADER_BYTES     = 16;
	localparam int unsigned ENTRY_BYTES      = 8;

	// Byte offsets never pass the header plus a full block table.
	localparam int unsigned OFF_W = 25;

	localparam logic [31:0] RST_MAX_DECODED = 32'd536870912;
	localparam logic [4:0]  RST_MIN_LOG2    = 5'd12;
	localparam logic [4:0]  RST_MAX_LOG2    = 5'd20;

	// Configuration register indexes.
	localparam logic [1:0] CFG_MAX_DECODED = 2'd0;
	localparam logic [1:0] CFG_MIN_LOG2    = 2'd1;
	localparam logic [1:0] CFG_MAX_LOG2    = 2'd2;

	// Header word positions.
	localparam logic [2:0] WI_MAGIC = 3'd0;
	localparam logic [2:0] WI_BSIZE = 3'd1;
	localparam logic [2:0] WI_CSIZE = 3'd2;
	localparam logic [2:0] WI_DSIZE = 3'd3;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_TABLE_C,
		PH_TABLE_U,
		PH_DONE
	} phase_t;

	typedef enum logic [3:0] {
		ST_VALID     = 4'd0,
		ST_PASSTHRU  = 4'd1,
		ST_BAD_MAGIC = 4'd2,
		ST_BAD_BSIZE = 4'd3,
		ST_BAD_DSIZE = 4'd4,
		ST_MISMATCH  = 4'd5,
		ST_BAD_ENTRY = 4'd6,
		ST_TOTALS    = 4'd7,
		ST_TRUNC     = 4'd8
	} status_t;

	typedef struct packed {
		logic [31:0] max_decoded;
		logic [4:0]  min_log2;
		logic [4:0]  max_log2;
	} cfg_t;

	// A word after classification by the front end.
	typedef struct packed {
		logic [31:0] hw;
		logic [31:0] flen;
		logic        first;
		logic        hw_zero;
		logic        is_magic;
		logic        is_pass;
		logic        is_pow2;
		logic [4:0]  lg;
	} fe_t;

	typedef struct packed {
		status_t     status;
		logic [20:0] block_count;
		logic [31:0] decoded_size;
		logic [31:0] payload_offset;
	} res_t;

endpackage

// ----- rtl/pbtc_if.sv -----
// Channel interfaces of the package block-table checker.
`timescale 1ns / 1ps

interface pbtc_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] header_word;
	logic [31:0] file_length;
	logic        first_word;

	modport source (output valid, header_word, file_length, first_word, input ready);
	modport sink (input valid, header_word, file_length, first_word, output ready);
endinterface

interface pbtc_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  status;
	logic [20:0] block_count;
	logic [31:0] decoded_size;
	logic [31:0] payload_offset;

	modport source (output valid, status, block_count, decoded_size, payload_offset,
		input ready);
	modport sink (input valid, status, block_count, decoded_size, payload_offset,
		output ready);
endinterface

interface pbtc_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/pbtc_front.sv -----
// Front end: accepts words and classifies each one independently of checker state.
`timescale 1ns / 1ps

module pbtc_front import pbtc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	pbtc_in_if.sink      words,
	output logic         item_valid_s1,
	output fe_t          item_s1,
	input  logic         q_ready
);

	logic move;
	fe_t  cls;

	assign move        = !item_valid_s1 || q_ready;
	assign words.ready = move;

	always_comb begin
		cls          = '0;
		cls.hw       = words.header_word;
		cls.flen     = words.file_length;
		cls.first    = words.first_word;
		cls.hw_zero  = (words.header_word == '0);
		cls.is_magic = (words.header_word == MAGIC_WORD);
		cls.is_pass  = (words.header_word == PASSTHROUGH_WORD);
		cls.is_pow2  = !cls.hw_zero &&
			((words.header_word & (words.header_word - 32'd1)) == '0);
		// Bit position of a single set bit; meaningless unless is_pow2.
		for (int i = 0; i < 32; i++) begin
			if (words.header_word[i]) begin
				cls.lg = cls.lg | 5'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (move) begin
			item_valid_s1 <= words.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (move && words.valid) begin
			item_s1 <= cls;
		end
	end

endmodule

// ----- rtl/pbtc_queue.sv -----
// Two-entry queue between the front end and the checking back end.
`timescale 1ns / 1ps

module pbtc_queue import pbtc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	input  fe_t  push_item,
	output logic push_ready,
	output logic pop_valid,
	output fe_t  pop_item,
	input  logic pop
);

	fe_t        mem [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;
	logic       push;

	assign push_ready = (count_q != 2'd2);
	assign push       = push_valid && push_ready;
	assign pop_valid  = (count_q != 2'd0);
	assign pop_item   = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_item;
		end
	end

endmodule

// ----- rtl/pbtc_back.sv -----
// Back end: walks the header and block table; at most one verdict per package.
`timescale 1ns / 1ps

module pbtc_back import pbtc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic q_valid,
	input  fe_t  q_item,
	output logic q_pop,
	output logic res_valid,
	output res_t res,
	input  logic res_ready
);

	phase_t            phase_q, phase_n, ph;
	logic [2:0]        wi_q, wi_n, wi;
	logic [4:0]        bl_q, bl_n, bl;
	logic [31:0]       cs_q, cs_n, cs;
	logic [31:0]       dt_q, dt_n, dt;
	logic [20:0]       bn_q, bn_n, bn;
	logic [20:0]       ei_q, ei_n, ei;
	logic [31:0]       pc_q, pc_n, pc;
	logic [32:0]       sc_q, sc_n, sc;
	logic [32:0]       sd_q, sd_n, sd;
	logic [OFF_W-1:0]  off_q, off_n, off;

	logic        advance;
	logic        active;
	logic        trunc;
	logic [32:0] blocks;
	logic        frac;
	logic [33:0] size_sum;
	logic        last;
	logic [31:0] expected;
	logic [33:0] ent_sum;
	logic [32:0] sd_add;
	logic        emit;
	status_t     st;
	res_t        res_n;

	assign advance = !res_valid || res_ready;
	assign q_pop   = q_valid && advance;

	// A first word restarts the package: state is taken as cleared.
	always_comb begin
		ph  = q_item.first ? PH_HEADER : phase_q;
		wi  = q_item.first ? '0 : wi_q;
		bl  = q_item.first ? '0 : bl_q;
		cs  = q_item.first ? '0 : cs_q;
		dt  = q_item.first ? '0 : dt_q;
		bn  = q_item.first ? '0 : bn_q;
		ei  = q_item.first ? '0 : ei_q;
		pc  = q_item.first ? '0 : pc_q;
		sc  = q_item.first ? '0 : sc_q;
		sd  = q_item.first ? '0 : sd_q;
		off = q_item.first ? '0 : off_q;
	end

	// Datapath terms for the decoded-size word and the table entries.
	always_comb begin
		active = (ph == PH_HEADER) || (ph == PH_TABLE_C) || (ph == PH_TABLE_U);
		trunc  = (33'(off) + 33'd4) > {1'b0, q_item.flen};
		frac   = |(q_item.hw & ~(32'hFFFF_FFFF << bl));
		blocks = {1'b0, q_item.hw >> bl} + 33'(frac);
		// compressed + payload start == length covers both the range and the equality.
		size_sum = 34'(cs) + 34'(HEADER_BYTES) + {10'b0, blocks[20:0], 3'b000};
		last     = (22'(ei) + 22'd1) == {1'b0, bn};
		expected = last ? (dt - sd[31:0]) : (32'd1 << bl);
		ent_sum  = {1'b0, sc} + {2'b00, pc};
		sd_add   = sd + {1'b0, q_item.hw};
	end

	always_comb begin
		phase_n = ph;
		wi_n    = wi;
		bl_n    = bl;
		cs_n    = cs;
		dt_n    = dt;
		bn_n    = bn;
		ei_n    = ei;
		pc_n    = pc;
		sc_n    = sc;
		sd_n    = sd;
		off_n   = off + OFF_W'(4);
		emit    = 1'b0;
		st      = ST_VALID;
		if (active) begin
			if (trunc) begin
				emit = 1'b1;
				st   = ST_TRUNC;
			end else begin
				case (ph)
					PH_HEADER: begin
						case (wi)
							WI_MAGIC: begin
								if (!q_item.is_magic) begin
									emit = 1'b1;
									st   = ST_BAD_MAGIC;
								end else begin
									wi_n = WI_BSIZE;
								end
							end
							WI_BSIZE: begin
								if (q_item.is_pass) begin
									emit = 1'b1;
									st   = ST_PASSTHRU;
								end else if (!q_item.is_pow2 || q_item.lg < cfg.min_log2 ||
										q_item.lg > cfg.max_log2) begin
									emit = 1'b1;
									st   = ST_BAD_BSIZE;
								end else begin
									bl_n = q_item.lg;
									wi_n = WI_CSIZE;
								end
							end
							WI_CSIZE: begin
								cs_n = q_item.hw;
								wi_n = WI_DSIZE;
							end
							default: begin
								dt_n = q_item.hw;
								if (q_item.hw_zero || q_item.hw > cfg.max_decoded ||
										blocks > 33'(MAX_BLOCKS)) begin
									emit = 1'b1;
									st   = ST_BAD_DSIZE;
								end else begin
									bn_n = blocks[20:0];
									if (size_sum != {2'b00, q_item.flen}) begin
										emit = 1'b1;
										st   = ST_MISMATCH;
									end else begin
										ei_n    = '0;
										phase_n = PH_TABLE_C;
									end
								end
							end
						endcase
					end
					PH_TABLE_C: begin
						pc_n    = q_item.hw;
						phase_n = PH_TABLE_U;
					end
					default: begin
						if (pc == '0 || ent_sum > {2'b00, cs} || q_item.hw_zero ||
								q_item.hw != expected) begin
							emit = 1'b1;
							st   = ST_BAD_ENTRY;
						end else begin
							sc_n = ent_sum[32:0];
							sd_n = sd_add;
							ei_n = ei + 21'd1;
							if (last) begin
								emit = 1'b1;
								if (ent_sum[32:0] != {1'b0, cs} || sd_add != {1'b0, dt}) begin
									st = ST_TOTALS;
								end else begin
									st = ST_VALID;
								end
							end else begin
								phase_n = PH_TABLE_C;
							end
						end
					end
				endcase
			end
			if (emit) begin
				phase_n = PH_DONE;
			end
		end
		res_n.status         = st;
		res_n.block_count    = bn_n;
		res_n.decoded_size   = dt_n;
		res_n.payload_offset = (bn_n != '0) ?
			(32'(HEADER_BYTES) + {8'b0, bn_n, 3'b000}) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			wi_q      <= '0;
			bl_q      <= '0;
			cs_q      <= '0;
			dt_q      <= '0;
			bn_q      <= '0;
			ei_q      <= '0;
			pc_q      <= '0;
			sc_q      <= '0;
			sd_q      <= '0;
			off_q     <= '0;
			res_valid <= 1'b0;
		end else begin
			if (q_pop) begin
				phase_q <= phase_n;
				wi_q    <= wi_n;
				bl_q    <= bl_n;
				cs_q    <= cs_n;
				dt_q    <= dt_n;
				bn_q    <= bn_n;
				ei_q    <= ei_n;
				pc_q    <= pc_n;
				sc_q    <= sc_n;
				sd_q    <= sd_n;
				off_q   <= off_n;
			end
			if (advance) begin
				res_valid <= q_pop && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			res <= res_n;
		end
	end

endmodule

// ----- rtl/package_block_table_checker_top.sv -----
// Top level of the package block-table checker.
`timescale 1ns / 1ps

// Checks the header and block table of a package streamed as 32-bit words.
// Channels:
//   words    - one transfer per header or table word, with the package length
//              and a first_word flag that starts a new package.
//   verdicts - at most one transfer per package carrying status, block count,
//              decoded size and payload offset, sent on the word deciding it.
//   cfg      - register writes (index 0 max decoded size, 1 min block log2,
//              2 max block log2); always ready. The user must write them
//              only while idle; the block does not enforce it.
// Words before the first first_word, and words after a verdict up to the
// next first_word, produce nothing. Throughput is one word per cycle unless
// a stalled receiver fills the queue. The deciding word passes the front-end
// classification register and then the queue, after which the back end
// checks the word and loads its output register with the verdict.
// A two-entry queue separates front and back, so the front keeps taking
// words while the back waits on a stalled receiver; when the queue fills,
// words.ready drops until the receiver takes the pending verdict.
// Reset clears the checker to idle and loads the register defaults
// (512 MiB, 4 KiB, 1 MiB).
module package_block_table_checker_top import pbtc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	pbtc_in_if.sink       words,
	pbtc_out_if.source    verdicts,
	pbtc_cfg_if.sink      cfg
);

	cfg_t cfg_q;
	logic fe_valid_s1;
	fe_t  fe_s1;
	logic q_push_ready;
	logic q_valid;
	fe_t  q_item;
	logic q_pop;
	logic res_valid;
	res_t res;

	// Configuration registers; the port never stalls.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_decoded <= RST_MAX_DECODED;
			cfg_q.min_log2    <= RST_MIN_LOG2;
			cfg_q.max_log2    <= RST_MAX_LOG2;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_MAX_DECODED: cfg_q.max_decoded <= cfg.data;
				CFG_MIN_LOG2:    cfg_q.min_log2    <= cfg.data[4:0];
				CFG_MAX_LOG2:    cfg_q.max_log2    <= cfg.data[4:0];
				default: begin
				end
			endcase
		end
	end

	// Classification does not depend on checker state, so it runs ahead.
	pbtc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.words         (words),
		.item_valid_s1 (fe_valid_s1),
		.item_s1       (fe_s1),
		.q_ready       (q_push_ready)
	);

	pbtc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fe_valid_s1),
		.push_item  (fe_s1),
		.push_ready (q_push_ready),
		.pop_valid  (q_valid),
		.pop_item   (q_item),
		.pop        (q_pop)
	);

	// The back end owns all package state and the verdict register.
	pbtc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (verdicts.ready)
	);

	assign verdicts.valid          = res_valid;
	assign verdicts.status         = res.status;
	assign verdicts.block_count    = res.block_count;
	assign verdicts.decoded_size   = res.decoded_size;
	assign verdicts.payload_offset = res.payload_offset;

endmodule

// ----- rtl/pbtc_checker.sv -----
// Port-level assertions for the package block-table checker, bound to the top level.
`timescale 1ns / 1ps

module pbtc_checker import pbtc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  status,
	input logic [20:0] block_count,
	input logic [31:0] decoded_size,
	input logic [31:0] payload_offset
);

	// Only the defined verdict codes are ever reported.
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_TRUNC)
		else $error("verdict status out of range");

	// A stalled verdict stays valid with its status, block count and payload offset held.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
			$stable(payload_offset) && $stable(block_count))
		else $error("stalled verdict changed");

	// The payload starts after the header and one entry per block.
	a_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && block_count != '0 |->
			payload_offset == 32'(HEADER_BYTES) + {8'b0, block_count, 3'b000})
		else $error("payload offset does not follow block count");

	a_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && block_count == '0 |-> payload_offset == '0)
		else $error("payload offset without block count");

	// Verdicts taken before the decoded size is read carry no sizes.
	a_early: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_BAD_MAGIC || status == ST_PASSTHRU ||
			status == ST_BAD_BSIZE) |-> block_count == '0 && decoded_size == '0)
		else $error("early verdict carries size fields");

endmodule

bind package_block_table_checker_top pbtc_checker u_pbtc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (verdicts.valid),
	.out_ready      (verdicts.ready),
	.status         (verdicts.status),
	.block_count    (verdicts.block_count),
	.decoded_size   (verdicts.decoded_size),
	.payload_offset (verdicts.payload_offset)
);

// ----- verif/package_block_table_checker_top_test.sv -----
// Self-checking testbench for the package block-table checker top level.
`timescale 1ns / 1ps

// The bench streams package headers and block tables into the checker and
// compares every verdict against a cycle-free model of the checker that runs
// in step with the accepted word transfers.
//
// How it works:
//   - The word sender (send_word) offers one word at a time and waits for the
//     transfer. At the transfer, the model consumes the same word and, when the
//     word decides a verdict, queues the expected verdict.
//   - The verdict receiver is a free-running process. It throttles ready in
//     random bursts and can hold ready low for a long stretch on request.
//   - The verdict checker compares each verdict transfer with the oldest
//     queued expectation, field by field.
//   - A watchdog ends the run when no transfer of any kind happens for too
//     long.
// Configuration writes are made only while the checker is idle. That means
// every expected verdict has arrived and a few extra cycles have passed, so
// that ignored words in the front-end register and queue have drained.
module package_block_table_checker_top_test;
	import pbtc_pkg::*;

	// Longest stretch without any transfer before the run is declared hung.
	// The long receiver hold-off below is far shorter than this.
	localparam int STALL_LIMIT    = 5000;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int RANDOM_WORDS   = 1050;
	localparam int CLOSING_WORDS  = 100;
	localparam int PHASE_PACKAGES = 25;
	// Extra wait after the last verdict, for ignored words still in flight.
	localparam int DRAIN_CYCLES   = 4;
	localparam int TAIL_CYCLES    = 10;

	// Kinds of damage applied to an otherwise well-formed package.
	typedef enum int {
		FLAW_NONE,
		FLAW_MAGIC,
		FLAW_PASS,
		FLAW_BSIZE,
		FLAW_DSIZE,
		FLAW_CSIZE,
		FLAW_ENTRY,
		FLAW_TOTALS,
		FLAW_TRUNC,
		FLAW_CUT
	} flaw_t;

	logic clk = 1'b0;
	logic arst_n;

	always #5 clk = ~clk;

	pbtc_in_if  words_if ();
	pbtc_out_if verdicts_if ();
	pbtc_cfg_if cfg_if ();

	package_block_table_checker_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.words    (words_if),
		.verdicts (verdicts_if),
		.cfg      (cfg_if)
	);

	// Model state: a mirror of the registers and of the per-package progress.
	cfg_t        live_cfg;
	phase_t      pkg_phase;
	logic [2:0]  pkg_widx;
	logic [4:0]  pkg_lg;
	logic [31:0] pkg_csize;
	logic [31:0] pkg_dtotal;
	logic [20:0] pkg_blocks;
	logic [20:0] pkg_entry;
	logic [31:0] pkg_pending;
	logic [32:0] pkg_sumc;
	logic [32:0] pkg_sumd;

	res_t        verdict_q[$];
	logic [31:0] pkg_words[$];
	logic [31:0] pkg_flen;

	int fail_count  = 0;
	int word_count  = 0;
	int rx_hold_req = 0;
	bit src_idle_en = 1'b0;
	bit snk_idle_en = 1'b0;

	function automatic void clear_pkg();
		pkg_widx    = WI_MAGIC;
		pkg_lg      = '0;
		pkg_csize   = '0;
		pkg_dtotal  = '0;
		pkg_blocks  = '0;
		pkg_entry   = '0;
		pkg_pending = '0;
		pkg_sumc    = '0;
		pkg_sumd    = '0;
	endfunction

	// Closes the current package with the given status. Fields that were never
	// reached stay zero, because the state was cleared at the first word.
	function automatic bit close_pkg(input status_t st, output res_t r);
		r.status         = st;
		r.block_count    = pkg_blocks;
		r.decoded_size   = pkg_dtotal;
		r.payload_offset = (pkg_blocks != 0) ?
			32'(HEADER_BYTES + ENTRY_BYTES * 32'(pkg_blocks)) : 32'd0;
		pkg_phase = PH_DONE;
		return 1'b1;
	endfunction

	// Consumes one accepted word; returns 1 when the word decides a verdict.
	function automatic bit predict_verdict(input logic [31:0] hw, input logic [31:0] flen,
		input logic first, output res_t r);
		longint unsigned offs, bsize, nblk, start, room, want, c, u;
		logic [4:0] lg;
		bit last_entry;
		r = '0;
		if (first) begin
			clear_pkg();
			pkg_phase = PH_HEADER;
		end
		if (pkg_phase != PH_HEADER && pkg_phase != PH_TABLE_C && pkg_phase != PH_TABLE_U)
			return 1'b0;

		// Truncation is judged on the byte position of the word, before its value.
		if (pkg_phase == PH_HEADER)
			offs = 4 * 64'(pkg_widx);
		else
			offs = HEADER_BYTES + ENTRY_BYTES * 64'(pkg_entry) +
				((pkg_phase == PH_TABLE_U) ? 4 : 0);
		if (offs + 4 > 64'(flen))
			return close_pkg(ST_TRUNC, r);

		if (pkg_phase == PH_HEADER) begin
			case (pkg_widx)
				WI_MAGIC: begin
					if (hw != MAGIC_WORD)
						return close_pkg(ST_BAD_MAGIC, r);
					pkg_widx = WI_BSIZE;
				end
				WI_BSIZE: begin
					if (hw == PASSTHROUGH_WORD)
						return close_pkg(ST_PASSTHRU, r);
					if (hw == 0 || (hw & (hw - 1)) != 0)
						return close_pkg(ST_BAD_BSIZE, r);
					lg = '0;
					for (int i = 0; i < 32; i++)
						if (hw[i])
							lg = 5'(i);
					if (lg < live_cfg.min_log2 || lg > live_cfg.max_log2)
						return close_pkg(ST_BAD_BSIZE, r);
					pkg_lg   = lg;
					pkg_widx = WI_CSIZE;
				end
				WI_CSIZE: begin
					pkg_csize = hw;
					pkg_widx  = WI_DSIZE;
				end
				default: begin
					pkg_dtotal = hw;
					if (hw == 0 || hw > live_cfg.max_decoded)
						return close_pkg(ST_BAD_DSIZE, r);
					bsize = 64'd1 << pkg_lg;
					nblk  = (64'(hw) + bsize - 1) >> pkg_lg;
					if (nblk > MAX_BLOCKS)
						return close_pkg(ST_BAD_DSIZE, r);
					pkg_blocks = 21'(nblk);
					start = HEADER_BYTES + ENTRY_BYTES * nblk;
					if (start > 64'(flen) || 64'(pkg_csize) != 64'(flen) - start)
						return close_pkg(ST_MISMATCH, r);
					pkg_entry = '0;
					pkg_phase = PH_TABLE_C;
				end
			endcase
			return 1'b0;
		end

		if (pkg_phase == PH_TABLE_C) begin
			pkg_pending = hw;
			pkg_phase   = PH_TABLE_U;
			return 1'b0;
		end

		// Second word of an entry: compare the pair with the running totals.
		c = 64'(pkg_pending);
		u = 64'(hw);
		last_entry = (32'(pkg_entry) + 1) == 32'(pkg_blocks);
		room = (pkg_sumc <= pkg_csize) ? 64'(pkg_csize) - 64'(pkg_sumc) : 0;
		if (last_entry)
			want = (64'(pkg_dtotal) - 64'(pkg_sumd)) & 64'hFFFF_FFFF;
		else
			want = 64'd1 << pkg_lg;
		if (c == 0 || c > room || u == 0 || u != want)
			return close_pkg(ST_BAD_ENTRY, r);
		pkg_sumc  = pkg_sumc + 33'(c);
		pkg_sumd  = pkg_sumd + 33'(u);
		pkg_entry = pkg_entry + 1'b1;
		if (last_entry) begin
			if (pkg_sumc != 33'(pkg_csize) || pkg_sumd != 33'(pkg_dtotal))
				return close_pkg(ST_TOTALS, r);
			return close_pkg(ST_VALID, r);
		end
		pkg_phase = PH_TABLE_C;
		return 1'b0;
	endfunction

	// Builds one package in pkg_words/pkg_flen under the current register
	// settings. Block counts stay small so that tables are short.
	function automatic void build_package(input flaw_t flaw);
		logic [4:0] lg;
		longint unsigned bsize, nblk, cap, dsize, csize, flen;
		logic [31:0] csz[$];
		int j, keep;
		if (live_cfg.min_log2 <= live_cfg.max_log2)
			lg = 5'($urandom_range(live_cfg.min_log2, live_cfg.max_log2));
		else
			lg = 5'($urandom_range(0, 31));
		bsize = 64'd1 << lg;
		nblk  = ($urandom_range(0, 39) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
		// Keep the decoded size within 32 bits for large block sizes.
		cap = 64'hFFFF_FFFF >> lg;
		if (nblk > cap)
			nblk = cap;
		dsize = (nblk - 1) * bsize + $urandom_range(1, 32'(bsize));
		csize = 0;
		for (j = 0; j < nblk; j++) begin
			csz.push_back($urandom_range(1, 3000));
			csize += csz[j];
		end
		flen = HEADER_BYTES + ENTRY_BYTES * nblk + csize;
		pkg_words = '{MAGIC_WORD, 32'(bsize), 32'(csize), 32'(dsize)};
		for (j = 0; j < nblk; j++) begin
			pkg_words.push_back(csz[j]);
			pkg_words.push_back((j == nblk - 1) ? 32'(dsize - (nblk - 1) * bsize) : 32'(bsize));
		end
		case (flaw)
			FLAW_MAGIC: pkg_words[0] = MAGIC_WORD ^ ($urandom | 32'd1);
			FLAW_PASS: pkg_words[1] = PASSTHROUGH_WORD;
			FLAW_BSIZE: begin
				case ($urandom_range(0, 2))
					0: pkg_words[1] = '0;
					1: pkg_words[1] = $urandom | 32'h0000_0011;
					default: pkg_words[1] = 32'd1 << $urandom_range(0, 31);
				endcase
			end
			FLAW_DSIZE: begin
				if ($urandom_range(0, 1) == 0 || live_cfg.max_decoded == 32'hFFFF_FFFF)
					pkg_words[3] = '0;
				else
					pkg_words[3] = $urandom_range(live_cfg.max_decoded + 1, 32'hFFFF_FFFF);
			end
			FLAW_CSIZE: pkg_words[2] = pkg_words[2] ^ $urandom_range(1, 255);
			FLAW_ENTRY: begin
				j = $urandom_range(0, int'(nblk) - 1);
				case ($urandom_range(0, 3))
					0: pkg_words[4 + 2 * j] = '0;
					1: pkg_words[4 + 2 * j] = 32'(csize + 1);
					2: pkg_words[5 + 2 * j] = '0;
					default: pkg_words[5 + 2 * j] ^= 32'd1 << $urandom_range(0, 31);
				endcase
			end
			FLAW_TOTALS: begin
				// Header sizes stay consistent, but the entries fall short.
				j = $urandom_range(1, 500);
				pkg_words[2] += j;
				flen += j;
			end
			FLAW_TRUNC: flen = $urandom_range(0, 15);
			FLAW_CUT: begin
				// The next package's first word cuts this one off.
				keep = $urandom_range(1, pkg_words.size() - 1);
				while (pkg_words.size() > keep)
					void'(pkg_words.pop_back());
			end
			default: ;
		endcase
		pkg_flen = flen[31:0];
	endfunction

	// Offers one word and waits for its transfer, with an optional idle burst
	// before it. The model consumes the word at the transfer edge.
	task automatic send_word(input logic [31:0] hw, input logic [31:0] flen, input logic first);
		res_t r;
		if (src_idle_en && $urandom_range(0, 5) == 0) begin
			words_if.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		words_if.valid       <= 1'b1;
		words_if.header_word <= hw;
		words_if.file_length <= flen;
		words_if.first_word  <= first;
		do @(posedge clk); while (!words_if.ready);
		word_count++;
		if (predict_verdict(hw, flen, first, r))
			verdict_q.push_back(r);
	endtask

	task automatic send_package(input logic [31:0] flen);
		foreach (pkg_words[i])
			send_word(pkg_words[i], flen, i == 0);
	endtask

	// Stops offering words until every expected verdict has arrived, then lets
	// any ignored words still in flight leave the pipeline.
	task automatic wait_drain();
		words_if.valid <= 1'b0;
		@(posedge clk);
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		do @(posedge clk); while (!cfg_if.ready);
		case (idx)
			CFG_MAX_DECODED: live_cfg.max_decoded = val;
			CFG_MIN_LOG2:    live_cfg.min_log2    = val[4:0];
			CFG_MAX_LOG2:    live_cfg.max_log2    = val[4:0];
			default: ;
		endcase
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [31:0] maxd, input logic [4:0] minl,
		input logic [4:0] maxl);
		wait_drain();
		cfg_write(CFG_MAX_DECODED, maxd);
		cfg_write(CFG_MIN_LOG2, 32'(minl));
		cfg_write(CFG_MAX_LOG2, 32'(maxl));
	endtask

	// Header checks and special cases under the reset register values.
	task automatic test_directed();
		// A word before any package start must be ignored.
		send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		send_word(MAGIC_WORD, 32'd3, 1'b1);
		send_word(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
		send_word(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
		pkg_words = '{MAGIC_WORD, PASSTHROUGH_WORD};
		send_package(32'd8);
		// A word after a verdict is ignored until the next package start.
		send_word(MAGIC_WORD, 32'hFFFF_FFFF, 1'b0);
		pkg_words = '{MAGIC_WORD, 32'd0};
		send_package(32'd100);
		pkg_words = '{MAGIC_WORD, 32'h0000_3000};
		send_package(32'd100);
		pkg_words = '{MAGIC_WORD, 32'd1 << 11};
		send_package(32'd100);
		pkg_words = '{MAGIC_WORD, 32'd1 << 21};
		send_package(32'd100);
		pkg_words = '{MAGIC_WORD, 32'd4096, 32'd123};
		send_package(32'd11);
		pkg_words = '{MAGIC_WORD, 32'd4096, 32'd0, 32'd0};
		send_package(32'd1000);
		pkg_words = '{MAGIC_WORD, 32'd4096, 32'd0, RST_MAX_DECODED + 1};
		send_package(32'd1000);
		pkg_words = '{MAGIC_WORD, 32'd4096, 32'd100, 32'd4096};
		send_package(32'd125);
		pkg_words = '{MAGIC_WORD, 32'd1 << 20, 32'd100, 32'd1 << 20, 32'd100, 32'd1 << 20};
		send_package(32'd124);
		pkg_words = '{MAGIC_WORD, 32'd4096, 32'd30, 32'd5000, 32'd10, 32'd4096, 32'd20,
			32'd904};
		send_package(32'd62);
	endtask

	// Register extremes: smallest and largest limits, the empty block range
	// and block counts at and beyond the table limit.
	task automatic test_config_extremes();
		set_config(32'd1, 5'd0, 5'd0);
		pkg_words = '{MAGIC_WORD, 32'd1, 32'd5, 32'd1, 32'd5, 32'd1};
		send_package(32'd29);
		pkg_words = '{MAGIC_WORD, 32'd1, 32'd0, 32'd2};
		send_package(32'd1000);

		set_config(32'hFFFF_FFFF, 5'd0, 5'd0);
		// Four billion one-byte blocks is far beyond the table limit.
		pkg_words = '{MAGIC_WORD, 32'd1, 32'd0, 32'hFFFF_FFFF};
		send_package(32'hFFFF_FFFF);
		// Exactly the largest block count; the sizes disagree by one byte.
		pkg_words = '{MAGIC_WORD, 32'd1, 32'd8, MAX_BLOCKS};
		send_package(32'h0080_0010 + 32'd7);

		set_config(32'hFFFF_FFFF, 5'd31, 5'd31);
		pkg_words = '{MAGIC_WORD, 32'h8000_0000, 32'd9, 32'hFFFF_FFFF, 32'd4, 32'h8000_0000,
			32'd5, 32'h7FFF_FFFF};
		send_package(32'd41);
		pkg_words = '{MAGIC_WORD, 32'h4000_0000};
		send_package(32'd100);

		set_config(RST_MAX_DECODED, 5'd20, 5'd12);
		pkg_words = '{MAGIC_WORD, 32'd1 << 16};
		send_package(32'd100);
	endtask

	// The receiver holds off for a long stretch while one-word packages keep
	// coming, so the internal queue fills and the word input stalls.
	task automatic test_receiver_stall();
		src_idle_en = 1'b0;
		snk_idle_en = 1'b0;
		rx_hold_req = RX_HOLD_CYCLES;
		repeat (40)
			send_word(MAGIC_WORD ^ ($urandom | 32'd1), $urandom | 32'h10, 1'b1);
		// The sender now pauses until every verdict has been taken.
		wait_drain();
	endtask

	task automatic random_config();
		logic [31:0] maxd;
		int minl, maxl;
		case ($urandom_range(0, 7))
			0: begin minl = 0; maxl = 31; end
			1: begin minl = 31; maxl = 31; end
			2: begin minl = 0; maxl = 0; end
			3: begin
				minl = $urandom_range(1, 31);
				maxl = $urandom_range(0, minl - 1);
			end
			default: begin
				minl = $urandom_range(0, 20);
				maxl = minl + $urandom_range(0, 11);
				if (maxl > 31)
					maxl = 31;
			end
		endcase
		case ($urandom_range(0, 4))
			0: maxd = 32'hFFFF_FFFF;
			1: maxd = $urandom_range(1, 1 << 16);
			2: maxd = RST_MAX_DECODED;
			default: maxd = $urandom | 32'h8000_0000;
		endcase
		set_config(maxd, 5'(minl), 5'(maxl));
	endtask

	// Packages with random content, 45 percent well-formed, 45 percent damaged,
	// the rest stray words, until the requested number of words is used.
	task automatic run_random(input int words_wanted);
		int start, pick;
		start = word_count;
		while (word_count - start < words_wanted) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				send_word($urandom, $urandom, 1'b1);
			end else if (pick < 10) begin
				send_word($urandom, $urandom, 1'b0);
			end else begin
				if (pick < 55)
					build_package(FLAW_NONE);
				else
					build_package(flaw_t'($urandom_range(FLAW_MAGIC, FLAW_CUT)));
				send_package(pkg_flen);
			end
		end
	endtask

	task automatic test_random_packages();
		int start;
		start = word_count;
		while (word_count - start < RANDOM_WORDS) begin
			random_config();
			src_idle_en = $urandom_range(0, 3) != 0;
			snk_idle_en = $urandom_range(0, 3) != 0;
			run_random(PHASE_PACKAGES * 6);
		end
	endtask

	// Back-to-back traffic with no idling on either side.
	task automatic test_closing_run();
		random_config();
		src_idle_en = 1'b0;
		snk_idle_en = 1'b0;
		run_random(CLOSING_WORDS);
	endtask

	// Verdict receiver. Random idle bursts when enabled; a hold-off request is
	// counted down here, independent of the sender.
	initial begin : verdict_receiver
		int hold, gap;
		hold = 0;
		gap  = 0;
		verdicts_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_req > 0) begin
				hold        = rx_hold_req;
				rx_hold_req = 0;
			end
			if (hold > 0) begin
				hold--;
				verdicts_if.ready <= 1'b0;
			end else if (gap > 0) begin
				gap--;
				verdicts_if.ready <= 1'b0;
			end else if (snk_idle_en && $urandom_range(0, 6) == 0) begin
				gap = $urandom_range(1, 5) - 1;
				verdicts_if.ready <= 1'b0;
			end else begin
				verdicts_if.ready <= 1'b1;
			end
		end
	end

	// Verdict checker: each transfer is matched against the oldest expectation.
	always @(posedge clk) begin : verdict_check
		res_t want;
		if (arst_n && verdicts_if.valid && verdicts_if.ready) begin
			if (verdict_q.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected verdict: status %0d blocks %0d size %h offset %h",
						verdicts_if.status, verdicts_if.block_count,
						verdicts_if.decoded_size, verdicts_if.payload_offset);
			end else begin
				want = verdict_q.pop_front();
				if (verdicts_if.status !== want.status ||
					verdicts_if.block_count !== want.block_count ||
					verdicts_if.decoded_size !== want.decoded_size ||
					verdicts_if.payload_offset !== want.payload_offset) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("verdict mismatch: expected status %0d blocks %0d size %h offset %h",
							want.status, want.block_count, want.decoded_size,
							want.payload_offset);
						$display("                  got status %0d blocks %0d size %h offset %h",
							verdicts_if.status, verdicts_if.block_count,
							verdicts_if.decoded_size, verdicts_if.payload_offset);
					end
				end
			end
		end
	end

	// Watchdog: counts cycles in which no transfer happens on any channel.
	always @(posedge clk) begin : stall_watch
		int quiet;
		if (!arst_n) begin
			quiet = 0;
		end else if ((words_if.valid && words_if.ready) ||
			(verdicts_if.valid && verdicts_if.ready) || (cfg_if.valid && cfg_if.ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin : main_sequence
		words_if.valid       = 1'b0;
		words_if.header_word = '0;
		words_if.file_length = '0;
		words_if.first_word  = 1'b0;
		cfg_if.valid         = 1'b0;
		cfg_if.index         = CFG_MAX_DECODED;
		cfg_if.data          = '0;
		arst_n               = 1'b0;
		live_cfg.max_decoded = RST_MAX_DECODED;
		live_cfg.min_log2    = RST_MIN_LOG2;
		live_cfg.max_log2    = RST_MAX_LOG2;
		pkg_phase            = PH_IDLE;
		clear_pkg();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_en = 1'b1;
		snk_idle_en = 1'b1;
		test_directed();
		test_config_extremes();
		test_receiver_stall();
		test_random_packages();
		test_closing_run();

		// Let every verdict arrive, then watch a little longer for strays.
		wait_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && verdict_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
